### hdl/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

   // default geometry
   localparam int LIST_DEPTH  = 64;
   localparam int VALUE_WIDTH = 32;

   // port field widths
   localparam int OP_W     = 4;
   localparam int POS_W    = 6;
   localparam int VAL_IO_W = 32;
   localparam int STS_W    = 2;
   localparam int IDX_IO_W = 6;
   localparam int CNT_IO_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 4'd0,
      OP_INSERT    = 4'd1,
      OP_SET       = 4'd2,
      OP_FIND      = 4'd3,
      OP_REM_VALUE = 4'd4,
      OP_REM_INDEX = 4'd5,
      OP_REM_LAST  = 4'd6,
      OP_GET       = 4'd7,
      OP_CLEAR     = 4'd8
   } op_type;

   localparam logic [STS_W-1:0] STS_OK   = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL = 2'd1;
   localparam logic [STS_W-1:0] STS_BAD  = 2'd2;

endpackage

### hdl/ordered_list_engine_core.sv
`timescale 1ns / 1ps

// Ordered list engine: an ordered list of up to DEPTH values held in a RAM,
// plus a count of valid entries.
// Request channel (req_valid/req_ready): op, position, value_in. One request
// is worked at a time; req_ready is high only while the sequencer is idle.
// Response channel (rsp_valid/rsp_ready): status, value_out, index_out and
// entry_count, one response per request, held in an output register, so a
// new request is taken while the previous response still waits.
// Work per request, with N the entry count and p the position:
//   append, set, clear, failures on entry: straight to the response
//   get, remove last: one RAM read
//   find: reads from entry 0 up to the match, or all N on a miss
//   remove value: reads all N entries, hit or miss, moving those past the match down
//   remove at index: reads entry p, then moves the N - 1 - p above it down
//   insert: moves the N - p entries from p up, then writes the new value
// The walk over the RAM reads one entry and writes one per cycle through
// its single read and single write port.
// Reset (synchronous, active high) empties the list and drops any pending
// response; RAM contents are not cleared, as only entries below the count
// are ever read. A stalled receiver holds the response register and the
// sequencer waits in its final state until the register frees up.
module ordered_list_engine_core #(
   parameter int DEPTH       = ole_pkg::LIST_DEPTH,
   parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ole_pkg::OP_W-1:0]      req_op,
   input  logic [ole_pkg::POS_W-1:0]     req_position,
   input  logic [ole_pkg::VAL_IO_W-1:0]  req_value_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ole_pkg::STS_W-1:0]     rsp_status,
   output logic [ole_pkg::VAL_IO_W-1:0]  rsp_value_out,
   output logic [ole_pkg::IDX_IO_W-1:0]  rsp_index_out,
   output logic [ole_pkg::CNT_IO_W-1:0]  rsp_entry_count
);
   import ole_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SCAN = 6'b000010,   // walk for a match, or single read by index
      S_SHUP = 6'b000100,   // insert: move entries up
      S_INS  = 6'b001000,   // insert: drop new value in the gap
      S_SHDN = 6'b010000,   // remove: move entries down
      S_DONE = 6'b100000    // hand result to response register
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [IDX_W-1:0]       tgt_ff, tgt_in;
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   by_idx_ff, by_idx_in;

   logic [STS_W-1:0]       res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0] res_value_ff, res_value_in;
   logic [IDX_W-1:0]       res_index_ff, res_index_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [VAL_IO_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [IDX_IO_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [CNT_IO_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_rdata;

   // request decode helpers
   logic [VALUE_WIDTH-1:0] req_val;
   logic [CMP_W-1:0]       pos_c, cnt_c;
   logic [CNT_W-1:0]       count_m1;
   logic [IDX_W-1:0]       last_idx, cnt_idx, pos_idx;
   logic                   full, empty, pos_ok, hit;

   assign req_val  = VALUE_WIDTH'(req_value_in);
   assign pos_c    = CMP_W'(req_position);
   assign cnt_c    = CMP_W'(count_ff);
   assign count_m1 = count_ff - CNT_W'(1);
   assign last_idx = count_m1[IDX_W-1:0];
   assign cnt_idx  = count_ff[IDX_W-1:0];
   assign pos_idx  = pos_c[IDX_W-1:0];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pos_ok   = (pos_c < cnt_c);
   assign hit      = by_idx_ff || (ram_rdata == val_ff);

   ole_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      tgt_in        = tgt_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      by_idx_in     = by_idx_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = val_ff;
      ram_raddr     = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = op_type'(req_op);
               val_in        = req_val;
               res_status_in = STS_OK;
               res_value_in  = '0;
               res_index_in  = '0;
               state_in      = S_DONE;
               case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        res_status_in = STS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_idx;
                        ram_wdata = req_val;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        res_status_in = STS_FULL;
                     end else if (pos_c >= cnt_c) begin
                        // clamped to the end: plain append
                        ram_we    = 1'b1;
                        ram_waddr = cnt_idx;
                        ram_wdata = req_val;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        tgt_in    = pos_idx;
                        ptr_in    = last_idx;
                        ram_raddr = last_idx;
                        state_in  = S_SHUP;
                     end
                  end
                  OP_SET: begin
                     if (pos_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_idx;
                        ram_wdata = req_val;
                     end else begin
                        res_status_in = STS_BAD;
                     end
                  end
                  OP_FIND, OP_REM_VALUE: begin
                     if (empty) begin
                        res_status_in = STS_BAD;
                     end else begin
                        ptr_in    = '0;
                        ram_raddr = '0;
                        by_idx_in = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
                  OP_REM_INDEX, OP_GET: begin
                     if (pos_ok) begin
                        ptr_in    = pos_idx;
                        ram_raddr = pos_idx;
                        by_idx_in = 1'b1;
                        state_in  = S_SCAN;
                     end else begin
                        res_status_in = STS_BAD;
                     end
                  end
                  OP_REM_LAST: begin
                     if (empty) begin
                        res_status_in = STS_BAD;
                     end else begin
                        ptr_in    = last_idx;
                        ram_raddr = last_idx;
                        by_idx_in = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_status_in = STS_BAD;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // ram_rdata holds entries[ptr_ff]; prefetch the next one
            ram_raddr = ptr_ff + IDX_W'(1);
            if (hit) begin
               case (op_ff)
                  OP_FIND: begin
                     res_index_in = ptr_ff;
                     state_in     = S_DONE;
                  end
                  OP_GET: begin
                     res_value_in = ram_rdata;
                     state_in     = S_DONE;
                  end
                  default: begin
                     res_value_in = ram_rdata;
                     if (ptr_ff == last_idx) begin
                        count_in = count_m1;
                        state_in = S_DONE;
                     end else begin
                        ptr_in   = ptr_ff + IDX_W'(1);
                        state_in = S_SHDN;
                     end
                  end
               endcase
            end else if (ptr_ff == last_idx) begin
               res_status_in = STS_BAD;
               state_in      = S_DONE;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end

         S_SHDN: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff - IDX_W'(1);
            ram_wdata = ram_rdata;
            ram_raddr = ptr_ff + IDX_W'(1);
            if (ptr_ff == last_idx) begin
               count_in = count_m1;
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end

         S_SHUP: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff + IDX_W'(1);
            ram_wdata = ram_rdata;
            ram_raddr = ptr_ff - IDX_W'(1);
            if (ptr_ff == tgt_ff) begin
               state_in = S_INS;
            end else begin
               ptr_in = ptr_ff - IDX_W'(1);
            end
         end

         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = VAL_IO_W'(res_value_ff);
               rsp_index_in  = IDX_IO_W'(res_index_ff);
               rsp_count_in  = CNT_IO_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      tgt_ff        <= tgt_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      by_idx_ff     <= by_idx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_index_out   = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### hdl/ole_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module ole_ram #(
   parameter int WIDTH = ole_pkg::VALUE_WIDTH,
   parameter int DEPTH = ole_pkg::LIST_DEPTH
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   import ole_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
